@@ hdl/pcc_pkg.sv @@
`default_nettype none
package pcc_pkg;

  localparam int unsigned CoordW      = 20;
  localparam int unsigned LenW        = 12;
  localparam int unsigned CntW        = 16;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned ApbDataW    = 32;

  localparam int unsigned MaxPointsDef = 5000;

  localparam logic [LenW-1:0] RadiusRst    = 12'd250;
  localparam logic [LenW-1:0] HeightRst    = 12'd500;
  localparam logic [LenW-1:0] ClearanceRst = 12'd100;

  localparam int FloorMm     = 150;
  localparam int CeilMm      = 2000;
  localparam int MinInRadius = 10;

  typedef enum logic [1:0] {
    ReqStart = 2'd0,
    ReqPoint = 2'd1,
    ReqEnd   = 2'd2
  } pcc_req_e;

  typedef enum logic [1:0] {
    RegRadius    = 2'd0,
    RegHeight    = 2'd1,
    RegClearance = 2'd2
  } pcc_reg_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } pcc_in_t;

  typedef struct packed {
    logic            traversable;
    logic [CntW-1:0] in_radius_count;
  } pcc_out_t;

  typedef struct packed {
    logic [LenW-1:0]   radius;
    logic [2*LenW-1:0] radius_sq;
    logic [LenW-1:0]   height;
    logic [LenW-1:0]   clearance;
  } pcc_cfg_t;

  typedef struct packed {
    logic in_radius;
    logic zone;
    logic overhead;
  } pcc_class_t;

  // saturating increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/pcc_cfg.sv @@
`default_nettype none
module pcc_cfg
  import pcc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready,
  output      pcc_cfg_t            cfg_o
);

  pcc_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  logic [LenW-1:0] wval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[LenW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegRadius: begin
          cfg_d.radius    = wval;
          cfg_d.radius_sq = wval * wval;
        end
        RegHeight:    cfg_d.height    = wval;
        RegClearance: cfg_d.clearance = wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius    <= RadiusRst;
      cfg_q.radius_sq <= RadiusRst * RadiusRst;
      cfg_q.height    <= HeightRst;
      cfg_q.clearance <= ClearanceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegRadius:    prdata = ApbDataW'(cfg_q.radius);
      RegHeight:    prdata = ApbDataW'(cfg_q.height);
      RegClearance: prdata = ApbDataW'(cfg_q.clearance);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hdl/pcc_geom.sv @@
`default_nettype none
module pcc_geom
  import pcc_pkg::*;
(
  input  wire pcc_cfg_t                 cfg_i,
  input  wire logic signed [CoordW-1:0] query_x_i,
  input  wire logic signed [CoordW-1:0] query_y_i,
  input  wire logic signed [CoordW-1:0] x_i,
  input  wire logic signed [CoordW-1:0] y_i,
  input  wire logic signed [CoordW-1:0] z_i,
  output      pcc_class_t               class_o
);

  localparam logic signed [CoordW:0] LenMax  = (CoordW+1)'((1 << LenW) - 1);
  localparam logic signed [CoordW:0] LenMin  = -LenMax;
  localparam logic signed [CoordW:0] FloorZ  = (CoordW+1)'(FloorMm);
  localparam logic signed [CoordW:0] CeilZ   = (CoordW+1)'(CeilMm);

  logic signed [CoordW:0] dx, dy, zs, h_s, top_s, ndx, ndy;
  logic                   far;
  logic [LenW-1:0]        mag_x, mag_y;
  logic [2*LenW-1:0]      sq_x, sq_y;
  logic [2*LenW:0]        d2;
  logic [LenW:0]          top;
  logic                   above_floor;

  assign dx  = {x_i[CoordW-1], x_i} - {query_x_i[CoordW-1], query_x_i};
  assign dy  = {y_i[CoordW-1], y_i} - {query_y_i[CoordW-1], query_y_i};
  assign ndx = -dx;
  assign ndy = -dy;

  // Any offset beyond the largest radius is out, so only 12-bit magnitudes get squared.
  assign far = (dx > LenMax) || (dx < LenMin) || (dy > LenMax) || (dy < LenMin);
  assign mag_x = dx[CoordW] ? ndx[LenW-1:0] : dx[LenW-1:0];
  assign mag_y = dy[CoordW] ? ndy[LenW-1:0] : dy[LenW-1:0];
  assign sq_x  = mag_x * mag_x;
  assign sq_y  = mag_y * mag_y;
  assign d2    = {1'b0, sq_x} + {1'b0, sq_y};

  assign top   = {1'b0, cfg_i.height} + {1'b0, cfg_i.clearance};
  assign zs    = {z_i[CoordW-1], z_i};
  assign h_s   = $signed({{(CoordW+1-LenW){1'b0}}, cfg_i.height});
  assign top_s = $signed({{(CoordW-LenW){1'b0}}, top});
  assign above_floor = (zs >= FloorZ);

  assign class_o.in_radius = !far && (d2 <= {1'b0, cfg_i.radius_sq});
  assign class_o.zone      = above_floor && (zs <= h_s);
  assign class_o.overhead  = above_floor && (zs > h_s) && (zs > top_s) && (zs <= CeilZ);

endmodule
`default_nettype wire

@@ hdl/point_cloud_clearance_check_top.sv @@
`default_nettype none
// Clearance check over a point-cloud stream. Send a start word carrying the
// query point, then cloud-point words (x, y, z in signed millimetres), then an
// end word; the end word yields one result word with the verdict and the count
// of points inside the check radius. A point is inside when dx^2 + dy^2 is at
// most radius^2; inside points are binned as robot zone (150 mm up to the
// robot height) or overhead (above height plus clearance, up to 2000 mm). The
// verdict is set when at least 10 points lie inside, at least one is overhead
// and 2*overhead > 3*zone. Only the first MaxPoints points after a start
// count; later ones are dropped until the next start. Counters saturate at
// 65535. Throughput is one word per clock unless the input side stalls: a word
// is held in the input register, where a single pass of subtract, two 12x12
// squares, add and compare updates the counters; an end word moves its verdict
// from the input register into the result register. The input side stalls only
// when an end word meets a result register that is still full and not being taken.
// Write the three configuration registers over APB (0x0 radius, 0x4 robot
// height, 0x8 clearance) while no query words are in flight.
module point_cloud_clearance_check_top
  import pcc_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire pcc_in_t             in_data_i,
  // result channel
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      pcc_out_t            out_data_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready
);

  localparam int unsigned ExamW = $clog2(MaxPoints + 1);
  localparam logic [ExamW-1:0] ExamLimit = ExamW'(MaxPoints);

  pcc_cfg_t   cfg;
  pcc_class_t cls;

  // input register
  logic    in_valid_q;
  pcc_in_t in_q;

  // query state
  logic signed [CoordW-1:0] query_x_q, query_x_d;
  logic signed [CoordW-1:0] query_y_q, query_y_d;
  logic [ExamW-1:0] exam_q, exam_d;
  logic [CntW-1:0]  radius_q, radius_d;
  logic [CntW-1:0]  zone_q, zone_d;
  logic [CntW-1:0]  over_q, over_d;

  // result register
  logic     out_valid_q, out_valid_d;
  pcc_out_t out_q, out_d;

  logic fire, is_end, verdict;
  logic [CntW+1:0] two_over, three_zone;

  pcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcc_geom u_geom (
    .cfg_i     (cfg),
    .query_x_i (query_x_q),
    .query_y_i (query_y_q),
    .x_i       (in_q.coord_x),
    .y_i       (in_q.coord_y),
    .z_i       (in_q.coord_z),
    .class_o   (cls)
  );

  // An end word needs room in the result register; everything else retires at once.
  assign is_end     = (in_q.req_type == ReqEnd);
  assign fire       = in_valid_q && (!is_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  assign two_over   = {1'b0, over_q, 1'b0};
  assign three_zone = {1'b0, zone_q, 1'b0} + {2'b00, zone_q};
  assign verdict    = (radius_q >= CntW'(MinInRadius)) && (over_q != '0) &&
                      (two_over > three_zone);

  always_comb begin
    query_x_d   = query_x_q;
    query_y_d   = query_y_q;
    exam_d      = exam_q;
    radius_d    = radius_q;
    zone_d      = zone_q;
    over_d      = over_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (fire) begin
      unique case (in_q.req_type)
        ReqStart: begin
          query_x_d = in_q.coord_x;
          query_y_d = in_q.coord_y;
          exam_d    = '0;
          radius_d  = '0;
          zone_d    = '0;
          over_d    = '0;
        end
        ReqPoint: begin
          // drop points once the budget is spent
          if (exam_q < ExamLimit) begin
            exam_d = exam_q + 1'b1;
            if (cls.in_radius) begin
              radius_d = sat_inc(radius_q);
              if (cls.zone) begin
                zone_d = sat_inc(zone_q);
              end
              if (cls.overhead) begin
                over_d = sat_inc(over_q);
              end
            end
          end
        end
        ReqEnd: begin
          out_valid_d           = 1'b1;
          out_d.traversable     = verdict;
          out_d.in_radius_count = radius_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      query_x_q   <= '0;
      query_y_q   <= '0;
      exam_q      <= '0;
      radius_q    <= '0;
      zone_q      <= '0;
      over_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      query_x_q   <= query_x_d;
      query_y_q   <= query_y_d;
      exam_q      <= exam_d;
      radius_q    <= radius_d;
      zone_q      <= zone_d;
      over_q      <= over_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
